FILE: sv/pcb_pkg.sv
package pcb_pkg;

  // Palette geometry.
  localparam int TABLE_ENTRIES = 16;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int CHAN_W        = 8;
  localparam int CHANNELS      = 3;
  localparam int COLOR_W       = CHAN_W * CHANNELS;
  localparam int INDEX_W       = 16;

  // Brightness that passes a colour unchanged.
  localparam logic [CHAN_W-1:0] BRIGHT_FULL = 8'hFF;
  localparam logic [CHAN_W-1:0] BRIGHT_OFF  = 8'h00;

  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [2*CHAN_W-1:0] prod_t;

  // Item codes carried on the mode field.
  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_LOOK8  = 2'd1,
    MODE_LOOK16 = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

endpackage

FILE: sv/pcb_if.sv
// Input channel: table writes and palette lookups.
interface pcb_in_if;
  import pcb_pkg::*;

  logic   valid;
  logic   ready;
  mode_t  mode;
  index_t index;
  slot_t  entry_slot;
  color_t entry_color;

  modport source (output valid, output mode, output index, output entry_slot,
                  output entry_color, input ready);
  modport sink   (input valid, input mode, input index, input entry_slot,
                  input entry_color, output ready);
endinterface

// Output channel: one blended colour per lookup.
interface pcb_out_if;
  import pcb_pkg::*;

  logic   valid;
  logic   ready;
  color_t color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

FILE: sv/palette_color_blend.sv
// Channel     Role    Beat contents
// ----------  ------  -----------------------------------------------
// pix_in      sink    mode, index, entry_slot, entry_color
// pix_out     source  color (red 23..16, green 15..8, blue 7..0)
// cfg_we/wd   write   brightness (8 bits)
//
// Five register stages: table read, blend products, blend sum, brightness
// product, output register. A lookup's colour is offered from the output register;
// one beat is accepted every cycle while the output is taken.
// A stall on pix_out freezes all stages together, so nothing is lost or repeated.
// Reset (rst, synchronous) clears the stage valid bits and the table entry
// valid bits, and sets brightness to full scale. Write beats give no result.
module palette_color_blend (
  input  logic            clk,
  input  logic            rst,
  pcb_in_if.sink          pix_in,
  pcb_out_if.source       pix_out,
  input  logic            cfg_we,
  input  pcb_pkg::chan_t  cfg_wdata
);
  import pcb_pkg::*;

  // Brightness register.
  chan_t brightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_FULL;
    end else if (cfg_we) begin
      brightness <= cfg_wdata;
    end
  end

  // Pipeline advance: all stages move together when the output is free.
  logic adv;
  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld;

  assign adv          = !s5_vld || pix_out.ready;
  assign pix_in.ready = adv;

  logic acc;
  logic is_lookup;
  logic wr_en;

  assign acc       = pix_in.valid && pix_in.ready;
  assign is_lookup = (pix_in.mode == MODE_LOOK8) || (pix_in.mode == MODE_LOOK16);
  assign wr_en     = acc && (pix_in.mode == MODE_WRITE);

  // Index decode into entry and blend weight.
  slot_t slot_cur, slot_nxt;
  chan_t weight_in;

  always_comb begin
    if (pix_in.mode == MODE_LOOK16) begin
      slot_cur  = pix_in.index[15:12];
      weight_in = pix_in.index[11:4];
    end else begin
      slot_cur  = pix_in.index[7:4];
      weight_in = {pix_in.index[3:0], 4'b0000};
    end
    slot_nxt = slot_cur + slot_t'(1);
  end

  // Table entry valid bits: an entry never written reads as black.
  logic [TABLE_ENTRIES-1:0] entry_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_en) begin
      entry_vld[pix_in.entry_slot] <= 1'b1;
    end
  end

  color_t rd_cur, rd_nxt;

  pcb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (pix_in.entry_slot),
    .wdata   (pix_in.entry_color),
    .re      (adv),
    .raddr_a (slot_cur),
    .raddr_b (slot_nxt),
    .rdata_a (rd_cur),
    .rdata_b (rd_nxt)
  );

  // Stage 1: table read data with its entry valid bits and the weight.
  logic  s1_cur_vld, s1_nxt_vld;
  chan_t s1_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= acc && is_lookup;
    end
    if (adv) begin
      s1_cur_vld <= entry_vld[slot_cur];
      s1_nxt_vld <= entry_vld[slot_nxt];
      s1_weight  <= weight_in;
    end
  end

  color_t s1_cur, s1_nxt;

  assign s1_cur = s1_cur_vld ? rd_cur : '0;
  assign s1_nxt = s1_nxt_vld ? rd_nxt : '0;

  // Stage 2: per-channel blend products.
  prod_t [CHANNELS-1:0] s2_prod_c, s2_prod_n;
  chan_t [CHANNELS-1:0] s2_chan;
  logic                 s2_no_blend;
  chan_t                inv_weight;

  assign inv_weight = BRIGHT_FULL - s1_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
    if (adv) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        s2_prod_c[ch] <= s1_cur[ch*CHAN_W +: CHAN_W] * inv_weight;
        s2_prod_n[ch] <= s1_nxt[ch*CHAN_W +: CHAN_W] * s1_weight;
        s2_chan[ch]   <= s1_cur[ch*CHAN_W +: CHAN_W];
      end
      s2_no_blend <= (s1_weight == '0);
    end
  end

  // Stage 3: blend sum, or the entry itself when the weight is zero.
  chan_t [CHANNELS-1:0] s3_chan;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
    if (adv) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (s2_no_blend) begin
          s3_chan[ch] <= s2_chan[ch];
        end else begin
          s3_chan[ch] <= s2_prod_c[ch][2*CHAN_W-1:CHAN_W]
                       + s2_prod_n[ch][2*CHAN_W-1:CHAN_W];
        end
      end
    end
  end

  // Stage 4: brightness product per channel.
  logic [CHAN_W:0]              bright_p1;
  logic [2*CHAN_W:0]            s4_prod [CHANNELS];
  chan_t [CHANNELS-1:0]         s4_chan;

  assign bright_p1 = {1'b0, brightness} + (CHAN_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
    if (adv) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        s4_prod[ch] <= {1'b0, s3_chan[ch]} * bright_p1;
        s4_chan[ch] <= s3_chan[ch];
      end
    end
  end

  // Stage 5: brightness selection into the output register.
  color_t s5_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= s4_vld;
    end
    if (adv) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (brightness == BRIGHT_FULL) begin
          s5_color[ch*CHAN_W +: CHAN_W] <= s4_chan[ch];
        end else if (brightness == BRIGHT_OFF || s4_chan[ch] == '0) begin
          s5_color[ch*CHAN_W +: CHAN_W] <= '0;
        end else begin
          s5_color[ch*CHAN_W +: CHAN_W] <= s4_prod[ch][2*CHAN_W-1:CHAN_W] + chan_t'(1);
        end
      end
    end
  end

  assign pix_out.valid = s5_vld;
  assign pix_out.color = s5_color;

`ifndef SYNTHESIS
  // An accepted beat enters stage 1 exactly when it is a lookup.
  a_lookup_enters: assert property (@(posedge clk) disable iff (rst)
    acc |=> (s1_vld == $past(is_lookup)))
    else $error("stage 1 valid does not follow the accepted beat");

  // A stall freezes every stage valid bit.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({s1_vld, s2_vld, s3_vld, s4_vld, s5_vld}))
    else $error("pipeline moved during a stall");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pix_out.valid)
    else $error("output valid right after reset");

  // A written entry is marked valid in the next cycle.
  a_entry_marked: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> entry_vld[$past(pix_in.entry_slot)])
    else $error("written table entry not marked valid");
`endif

endmodule

FILE: sv/pcb_ram.sv
module pcb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: test/palette_color_blend_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the brightness port, keeps its own copy of the
// palette and predicts the colour of every lookup beat in order of acceptance.
module palette_color_blend_checker (
  input  logic           clk,
  input  logic           rst,
  pcb_in_if              pix_in,
  pcb_out_if             pix_out,
  input  logic           cfg_we,
  input  pcb_pkg::chan_t cfg_wdata,
  output int             mismatches,
  output int             pending
);
  import pcb_pkg::*;

  color_t palette_copy [TABLE_ENTRIES];
  chan_t  bright_copy;
  color_t expected_colors [$];
  int     fail_count;

  // Weighted mix of one channel with the same channel of the next entry.
  function automatic chan_t mix_chan(chan_t c, chan_t n, chan_t w);
    prod_t keep;
    prod_t take;
    keep = prod_t'(c) * prod_t'(8'd255 - w);
    take = prod_t'(n) * prod_t'(w);
    return chan_t'(keep[15:8] + take[15:8]);
  endfunction

  // Global brightness: full scale passes, zero blanks, otherwise the channel
  // is scaled and nudged up by one so that a lit channel never goes dark.
  function automatic chan_t scale_chan(chan_t c, chan_t b);
    prod_t prod;
    if (b == BRIGHT_FULL) begin
      return c;
    end
    if (b == BRIGHT_OFF || c == '0) begin
      return '0;
    end
    prod = prod_t'(c) * prod_t'(b + 8'd1);
    return chan_t'(prod[15:8] + 8'd1);
  endfunction

  // Colour of a lookup: the slot blended towards its successor, which wraps
  // from the last entry back to entry 0.
  function automatic color_t blend_lookup(slot_t s, chan_t w);
    color_t cur;
    color_t nxt;
    color_t res;
    chan_t  v;
    cur = palette_copy[s];
    nxt = palette_copy[slot_t'(s + 1'b1)];
    res = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      v = (w != '0) ? mix_chan(cur[ch*CHAN_W +: CHAN_W], nxt[ch*CHAN_W +: CHAN_W], w)
                    : cur[ch*CHAN_W +: CHAN_W];
      res[ch*CHAN_W +: CHAN_W] = scale_chan(v, bright_copy);
    end
    return res;
  endfunction

  // Results are checked before new beats are predicted; a lookup cannot
  // produce its colour in the cycle it is accepted.
  always @(posedge clk) begin
    color_t want;
    if (rst) begin
      foreach (palette_copy[i]) palette_copy[i] = '0;
      bright_copy = BRIGHT_FULL;
      expected_colors.delete();
      fail_count = 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected colour beat, expected none, got %06h",
                   $time, pix_out.color);
          fail_count++;
        end else begin
          want = expected_colors.pop_front();
          if (pix_out.color !== want) begin
            $display("%0t: colour mismatch, expected %06h, got %06h",
                     $time, want, pix_out.color);
            fail_count++;
          end
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        case (pix_in.mode)
          MODE_WRITE: begin
            palette_copy[pix_in.entry_slot] = pix_in.entry_color;
          end
          MODE_LOOK8: begin
            expected_colors.push_back(blend_lookup(pix_in.index[7:4],
                                                   {pix_in.index[3:0], 4'h0}));
          end
          MODE_LOOK16: begin
            expected_colors.push_back(blend_lookup(pix_in.index[15:12],
                                                   pix_in.index[11:4]));
          end
          default: begin
          end
        endcase
      end
      if (cfg_we) begin
        bright_copy = cfg_wdata;
      end
    end
    pending    <= expected_colors.size();
    mismatches <= fail_count;
  end

endmodule

FILE: test/tb_palette_color_blend.sv
`timescale 1ns / 100ps

// Drives table writes and lookups through the palette blender under several
// brightness settings and idle patterns; the checker does the comparing.
module tb_palette_color_blend;
  import pcb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  chan_t       cfg_wdata;
  logic        sink_ready = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned take_stall_pct = 0;
  int          mismatches;
  int          pending;

  pcb_in_if  pix_in ();
  pcb_out_if pix_out ();

  assign pix_out.ready = sink_ready;

  palette_color_blend i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  palette_color_blend_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .pix_out    (pix_out),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= take_stall_pct);
  end

  // Offers one beat after a random idle stretch and holds it until taken.
  task automatic send_beat(mode_t m, index_t idx, slot_t s, color_t col);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid       <= 1'b1;
    pix_in.mode        <= m;
    pix_in.index       <= idx;
    pix_in.entry_slot  <= s;
    pix_in.entry_color <= col;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
  endtask

  // Lets every lookup come out, gives trailing writes time to settle, then
  // writes the brightness register.
  task automatic set_brightness(chan_t b);
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random beat, biased towards the weight and colour extremes.
  task automatic random_beat(output bit counted);
    mode_t  m;
    index_t idx;
    color_t col;
    slot_t  s;
    int     r;
    r = $urandom_range(99);
    if (r < 25) m = MODE_WRITE;
    else if (r < 60) m = MODE_LOOK8;
    else if (r < 95) m = MODE_LOOK16;
    else m = MODE_NONE;
    idx = index_t'($urandom);
    col = color_t'($urandom);
    s   = slot_t'($urandom);
    case ($urandom_range(7))
      0: idx[11:4] = 8'h00;
      1: idx[11:4] = 8'hFF;
      2: idx[3:0]  = 4'h0;
      3: idx[3:0]  = 4'hF;
      default: begin
      end
    endcase
    case ($urandom_range(7))
      0: col = '0;
      1: col = '1;
      2: col[$urandom_range(CHANNELS-1)*CHAN_W +: CHAN_W] = '0;
      3: col[$urandom_range(CHANNELS-1)*CHAN_W +: CHAN_W] = '1;
      default: begin
      end
    endcase
    send_beat(m, idx, s, col);
    counted = (m != MODE_NONE);
  endtask

  initial begin
    chan_t bright_plan [8];
    bit    counted;
    int    done;

    pix_in.valid       <= 1'b0;
    pix_in.mode        <= MODE_NONE;
    pix_in.index       <= '0;
    pix_in.entry_slot  <= '0;
    pix_in.entry_color <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: empty table, wrap-around, zero and full weights,
    // ignored index bits and an ignored mode.
    send_beat(MODE_LOOK8,  16'h0000, 4'd0,  24'h000000);
    send_beat(MODE_WRITE,  16'h0000, 4'd0,  24'hFFFFFF);
    send_beat(MODE_WRITE,  16'hFFFF, 4'd1,  24'h000000);
    send_beat(MODE_WRITE,  16'h0000, 4'd15, 24'h80FF01);
    send_beat(MODE_WRITE,  16'h0000, 4'd14, 24'h123456);
    send_beat(MODE_WRITE,  16'h0000, 4'd2,  24'h00FF00);
    send_beat(MODE_LOOK8,  16'h0000, 4'd0,  24'h000000);
    send_beat(MODE_LOOK8,  16'h000F, 4'd0,  24'h000000);
    send_beat(MODE_LOOK8,  16'h00F8, 4'd0,  24'h000000);
    send_beat(MODE_LOOK8,  16'hAB1F, 4'd0,  24'h000000);
    send_beat(MODE_LOOK8,  16'hFFE4, 4'd0,  24'h000000);
    send_beat(MODE_LOOK16, 16'h0000, 4'd0,  24'h000000);
    send_beat(MODE_LOOK16, 16'hFFFF, 4'd0,  24'h000000);
    send_beat(MODE_LOOK16, 16'h0FF0, 4'd0,  24'h000000);
    send_beat(MODE_LOOK16, 16'hE008, 4'd0,  24'h000000);
    send_beat(MODE_LOOK16, 16'h1800, 4'd0,  24'h000000);
    send_beat(MODE_LOOK16, 16'hE7F7, 4'd0,  24'h000000);
    send_beat(MODE_NONE,   16'hFFFF, 4'd0,  24'h000000);
    send_beat(MODE_LOOK8,  16'h0000, 4'd0,  24'h000000);
    send_beat(MODE_LOOK16, 16'h2FFF, 4'd0,  24'h000000);

    // Random phases: each writes a new brightness and uses one of four idle mixes.
    bright_plan[0] = BRIGHT_OFF;
    bright_plan[1] = 8'd1;
    bright_plan[2] = 8'd128;
    bright_plan[3] = 8'd254;
    bright_plan[4] = BRIGHT_FULL;
    bright_plan[5] = chan_t'($urandom_range(2, 253));
    bright_plan[6] = 8'd2;
    bright_plan[7] = chan_t'($urandom);
    for (int ph = 0; ph < 8; ph++) begin
      set_brightness(bright_plan[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
        1: begin send_idle_pct = 87; take_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  take_stall_pct = 87; end
        default: begin send_idle_pct = 16; take_stall_pct = 16; end
      endcase
      done = 0;
      while (done < 190) begin
        random_beat(counted);
        if (counted) done++;
      end
    end

    // Drain and give the verdict.
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
